>>> src/midi_track_event_encoder_macros.svh
// ----------------------------------------------------------------------------
// midi_track_event_encoder assertion macros
// Shared concurrent assertion forms, synchronous to clock, off in reset.
// ----------------------------------------------------------------------------
`ifndef MIDI_TRACK_EVENT_ENCODER_MACROS_SVH
`define MIDI_TRACK_EVENT_ENCODER_MACROS_SVH

// same-cycle implication
`define MTE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define MTE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> src/mte_pkg.sv
// ----------------------------------------------------------------------------
// mte_pkg
// Types, constants and helpers shared by the track event encoder.
// ----------------------------------------------------------------------------
package mte_pkg;

   localparam int unsigned TickWidth   = 32;
   localparam int unsigned CountWidth  = 32;
   localparam int unsigned PosWidth    = 3;
   localparam int unsigned QueueDepth  = 2;
   localparam int unsigned PtrWidth    = $clog2(QueueDepth);
   localparam int unsigned FillWidth   = $clog2(QueueDepth + 1);

   localparam logic       OpEvent      = 1'b0;
   localparam logic       OpEndTrack   = 1'b1;

   localparam logic [7:0] KindMask     = 8'hF0;
   localparam logic [7:0] KindProgram  = 8'hC0;
   localparam logic [7:0] KindPressure = 8'hD0;
   localparam logic [7:0] MetaStatus   = 8'hFF;
   localparam logic [7:0] MetaEndTrack = 8'h2F;
   localparam logic [7:0] ContBit      = 8'h80;

   localparam logic [PosWidth-1:0] EotLastPos = 3'd3;

   typedef struct packed {
      logic                  opcode;
      logic [TickWidth-1:0]  delta;
      logic [7:0]            status_byte;
      logic [6:0]            first_data;
      logic [6:0]            second_data;
      logic [PosWidth-1:0]   vlq_len;
      logic [PosWidth-1:0]   last_pos;
   } desc_type;

   typedef struct packed {
      logic not_empty;
      logic not_full;
   } queue_status_type;

   function automatic logic [7:0] eot_byte(input logic [PosWidth-1:0] pos);
      logic [7:0] b;
      unique case (pos)
         3'd1:    b = MetaStatus;
         3'd2:    b = MetaEndTrack;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
      return (&v) ? v : v + CountWidth'(1);
   endfunction

endpackage

>>> src/mte_channels.sv
// ----------------------------------------------------------------------------
// mte channel interfaces
// Valid/ready request and response channels of the track event encoder.
// ----------------------------------------------------------------------------
interface mte_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [31:0] event_tick;
   logic [7:0]  status_byte;
   logic [6:0]  first_data;
   logic [6:0]  second_data;

   modport source (output valid, opcode, event_tick, status_byte, first_data,
                   second_data, input ready);
   modport sink   (input valid, opcode, event_tick, status_byte, first_data,
                   second_data, output ready);
endinterface

interface mte_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        last_of_item;
   logic [31:0] track_length;

   modport source (output valid, out_byte, last_of_item, track_length, input ready);
   modport sink   (input valid, out_byte, last_of_item, track_length, output ready);
endinterface

>>> src/midi_track_event_encoder.sv
// ----------------------------------------------------------------------------
// midi_track_event_encoder - track body byte encoder
// Requests queue as descriptors; the first byte is then registered into the
// byte-wide response register, one byte per cycle while rsp_chan.ready holds;
// events are 3 to 8 bytes, EOT 4. Synchronous reset clears tick, count, queue.
// ----------------------------------------------------------------------------
module midi_track_event_encoder (
   input  logic       clock,
   input  logic       reset,
   mte_req_if.sink    req_chan,
   mte_rsp_if.source  rsp_chan
);
   import mte_pkg::*;
   `include "midi_track_event_encoder_macros.svh"

   logic             push;
   logic             pop;
   desc_type         push_desc;
   desc_type         head_desc;
   queue_status_type q_status;

   mte_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .q_status  (q_status),
      .push      (push),
      .push_desc (push_desc)
   );

   mte_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head_desc (head_desc),
      .q_status  (q_status)
   );

   mte_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_desc (head_desc),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

   `MTE_ASSERT_NOW(a_pop_needs_entry, clock, reset, pop, q_status.not_empty)
   `MTE_ASSERT_NOW(a_full_not_empty, clock, reset, !q_status.not_full, q_status.not_empty)
   `MTE_ASSERT_NEXT(a_pop_marks_last, clock, reset, pop,
                    rsp_chan.valid && rsp_chan.last_of_item)
   `MTE_ASSERT_NOW(a_length_only_last, clock, reset,
                   rsp_chan.valid && !rsp_chan.last_of_item, rsp_chan.track_length == '0)

endmodule

>>> src/mte_front.sv
// ----------------------------------------------------------------------------
// mte_front
// Accepts requests, forms the tick delta and its VLQ length, and the last byte
// position of the item; keeps the previous tick.
// ----------------------------------------------------------------------------
module mte_front (
   input  logic                       clock,
   input  logic                       reset,
   mte_req_if.sink                    req_chan,
   input  mte_pkg::queue_status_type  q_status,
   output logic                       push,
   output mte_pkg::desc_type          push_desc
);
   import mte_pkg::*;

   logic [TickWidth-1:0] prev_tick_ff, prev_tick_in;
   logic [TickWidth-1:0] delta;
   logic [PosWidth-1:0]  vlq_len;
   logic [7:0]           kind;
   logic                 drop_second;

   assign req_chan.ready = q_status.not_full;
   assign push           = req_chan.valid && q_status.not_full;

   assign delta       = req_chan.event_tick - prev_tick_ff;
   assign kind        = req_chan.status_byte & KindMask;
   assign drop_second = (kind == KindProgram) || (kind == KindPressure);

   always_comb begin
      priority if (delta[31:28] != '0) begin
         vlq_len = 3'd5;
      end else if (delta[27:21] != '0) begin
         vlq_len = 3'd4;
      end else if (delta[20:14] != '0) begin
         vlq_len = 3'd3;
      end else if (delta[13:7] != '0) begin
         vlq_len = 3'd2;
      end else begin
         vlq_len = 3'd1;
      end
   end

   always_comb begin
      push_desc.opcode      = req_chan.opcode;
      push_desc.delta       = delta;
      push_desc.status_byte = req_chan.status_byte;
      push_desc.first_data  = req_chan.first_data;
      push_desc.second_data = req_chan.second_data;
      push_desc.vlq_len     = vlq_len;
      if (req_chan.opcode == OpEndTrack) begin
         push_desc.last_pos = EotLastPos;
      end else begin
         push_desc.last_pos = vlq_len + (drop_second ? 3'd1 : 3'd2);
      end
   end

   always_comb begin
      prev_tick_in = prev_tick_ff;
      if (push) begin
         prev_tick_in = (req_chan.opcode == OpEndTrack) ? '0 : req_chan.event_tick;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_tick_ff <= '0;
      end else begin
         prev_tick_ff <= prev_tick_in;
      end
   end

endmodule

>>> src/mte_queue.sv
// ----------------------------------------------------------------------------
// mte_queue
// Short register queue of item descriptors between front and back.
// ----------------------------------------------------------------------------
module mte_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  mte_pkg::desc_type          push_desc,
   input  logic                       pop,
   output mte_pkg::desc_type          head_desc,
   output mte_pkg::queue_status_type  q_status
);
   import mte_pkg::*;

   desc_type               entry_ff [QueueDepth];
   logic [PtrWidth-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [FillWidth-1:0]   fill_ff, fill_in;

   function automatic logic [PtrWidth-1:0] ptr_next(input logic [PtrWidth-1:0] p);
      return (p == PtrWidth'(QueueDepth - 1)) ? '0 : p + PtrWidth'(1);
   endfunction

   assign head_desc          = entry_ff[rd_ptr_ff];
   assign q_status.not_empty = (fill_ff != '0);
   assign q_status.not_full  = (fill_ff != FillWidth'(QueueDepth));

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + FillWidth'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - FillWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

>>> src/mte_back.sv
// ----------------------------------------------------------------------------
// mte_back
// Walks the head descriptor one byte a cycle, while the response is taken, into
// the response register and keeps the saturating body byte count.
// ----------------------------------------------------------------------------
module mte_back (
   input  logic                       clock,
   input  logic                       reset,
   input  mte_pkg::desc_type          head_desc,
   input  mte_pkg::queue_status_type  q_status,
   output logic                       pop,
   mte_rsp_if.source                  rsp_chan
);
   import mte_pkg::*;

   logic [PosWidth-1:0]   pos_ff, pos_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  valid_ff, valid_in;
   logic [7:0]            byte_ff, byte_in;
   logic                  last_ff, last_in;
   logic [CountWidth-1:0] length_ff, length_in;
   logic                  load;
   logic                  at_last;
   logic [PosWidth-1:0]   grp_sel;
   logic [6:0]            grp;
   logic [CountWidth-1:0] count_next;

   assign load    = q_status.not_empty && (!valid_ff || rsp_chan.ready);
   assign at_last = (pos_ff == head_desc.last_pos);
   assign pop     = load && at_last;
   assign grp_sel = head_desc.vlq_len - 3'd1 - pos_ff;
   assign count_next = sat_inc(count_ff);

   always_comb begin
      unique case (grp_sel)
         3'd0:    grp = head_desc.delta[6:0];
         3'd1:    grp = head_desc.delta[13:7];
         3'd2:    grp = head_desc.delta[20:14];
         3'd3:    grp = head_desc.delta[27:21];
         default: grp = {3'b000, head_desc.delta[31:28]};
      endcase
   end

   always_comb begin
      if (head_desc.opcode == OpEndTrack) begin
         byte_in = eot_byte(pos_ff);
      end else if (pos_ff < head_desc.vlq_len) begin
         byte_in = {1'b0, grp} | ((grp_sel != '0) ? ContBit : 8'h00);
      end else if (pos_ff == head_desc.vlq_len) begin
         byte_in = head_desc.status_byte;
      end else if (pos_ff == head_desc.vlq_len + 3'd1) begin
         byte_in = {1'b0, head_desc.first_data};
      end else begin
         byte_in = {1'b0, head_desc.second_data};
      end
   end

   always_comb begin
      valid_in  = valid_ff;
      pos_in    = pos_ff;
      count_in  = count_ff;
      last_in   = last_ff;
      length_in = length_ff;
      if (load) begin
         valid_in  = 1'b1;
         last_in   = at_last;
         length_in = '0;
         pos_in    = at_last ? '0 : pos_ff + 3'd1;
         count_in  = count_next;
         if (at_last && head_desc.opcode == OpEndTrack) begin
            length_in = count_next;
            count_in  = '0;
         end
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff   <= byte_in;
      end
      last_ff   <= last_in;
      length_ff <= length_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= '0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
         count_ff <= count_in;
      end
   end

   assign rsp_chan.valid        = valid_ff;
   assign rsp_chan.out_byte     = byte_ff;
   assign rsp_chan.last_of_item = last_ff;
   assign rsp_chan.track_length = length_ff;

endmodule
